>>> rtl/core/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared constants and types for the dmx512 frame receiver.
// ----------------------------------------------------------------------------
package dmx_pkg;

    localparam int SLOT_COUNT_DEFAULT = 512;

    // fixed field widths
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int SLOT_IDX_W = 9;
    localparam int TIMEOUT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BREAK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_RELOAD = 2'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_AT_RESET = 3'd4;

    // frame position codes
    localparam int POS_IDLE       = 0;
    localparam int POS_START      = 1;
    localparam int POS_FIRST_SLOT = 2;

    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] addr;
        logic [BYTE_W-1:0]     data;
    } slot_wr_t;

endpackage

>>> rtl/core/dmx512_frame_receiver.sv
// ----------------------------------------------------------------------------
// dmx512_frame_receiver
// Event-driven dmx512 slot capture with activity and link lights.
// ----------------------------------------------------------------------------
// Input beats on s_* carry one event each: a received byte, a break, a timer
// tick or a host read of a stored slot (s_tuser selects which). Every input
// beat yields exactly one output beat on m_* with the read data and the two
// light levels after the event.
// An input beat reaches output valid through the input register, where the
// slot store read is issued, and then the result register. A new beat is
// taken every cycle while the output is not stalled; the slot store read
// port and its same-cycle write bypass set that rate.
// When m_tready is low the result register holds; the input register still
// accepts one more beat, then s_tready drops until the result is taken.
// Reset empties both registers, returns the frame to idle, loads the timeout
// with four, turns the link light on and the activity light off. The store
// reads as zero after reset through a fill mark, with no clearing pass.
// cfg_* writes device_address (index 0) or timeout_reload (index 1) and is
// always ready; other indexes are ignored.
// ----------------------------------------------------------------------------
module dmx512_frame_receiver #(
    parameter int SLOT_COUNT = dmx_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // rx_byte[7:0], slot_index[16:8]
    input  logic [7:0]                     s_tuser,   // kind[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // read_data[7:0], activity_led[8],
                                                      // link_led[9]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dmx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmx_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [dmx_pkg::SLOT_IDX_W-1:0] dev_addr_reg;
    logic [dmx_pkg::TIMEOUT_W-1:0]  reload_reg;

    logic                           a_valid_reg;
    logic [dmx_pkg::KIND_W-1:0]     a_kind_reg;
    logic [dmx_pkg::BYTE_W-1:0]     a_byte_reg;
    logic [dmx_pkg::SLOT_IDX_W-1:0] a_addr_reg;

    logic                           r_valid_reg;
    logic [15:0]                    r_data_reg;

    logic                           advance;
    logic                           accept;
    logic [dmx_pkg::KIND_W-1:0]     in_kind;
    logic [dmx_pkg::SLOT_IDX_W-1:0] rd_addr;
    logic [dmx_pkg::BYTE_W-1:0]     rd_data;
    dmx_pkg::slot_wr_t              wr;
    logic [dmx_pkg::BYTE_W-1:0]     read_data;
    logic                           activity_led;
    logic                           link_led;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= '0;
            reload_reg   <= dmx_pkg::TIMEOUT_AT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dmx_pkg::CFG_DEVICE_ADDRESS: dev_addr_reg <= cfg_data;
                dmx_pkg::CFG_TIMEOUT_RELOAD: reload_reg <= cfg_data[dmx_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance  = a_valid_reg && (!r_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign in_kind  = s_tuser[dmx_pkg::KIND_W-1:0];

    // a break looks up the addressed slot, a host read the requested one
    assign rd_addr = (in_kind == dmx_pkg::KIND_BREAK) ? dev_addr_reg : s_tdata[16:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg <= in_kind;
            a_byte_reg <= s_tdata[7:0];
            a_addr_reg <= rd_addr;
        end
    end

    dmx_slot_ram #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_data (rd_data)
    );

    dmx_frame_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .kind           (a_kind_reg),
        .rx_byte        (a_byte_reg),
        .rd_addr        (a_addr_reg),
        .rd_data        (rd_data),
        .timeout_reload (reload_reg),
        .wr             (wr),
        .read_data      (read_data),
        .activity_led   (activity_led),
        .link_led       (link_led)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            r_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            r_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_data_reg <= {6'b0, link_led, activity_led, read_data};
        end
    end

    assign m_tvalid = r_valid_reg;
    assign m_tdata  = r_data_reg;

endmodule

>>> rtl/core/dmx_slot_ram.sv
// ----------------------------------------------------------------------------
// dmx_slot_ram
// Slot store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dmx_slot_ram #(
    parameter int SLOT_COUNT = dmx_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [dmx_pkg::SLOT_IDX_W-1:0] rd_addr,
    input  dmx_pkg::slot_wr_t           wr,
    output logic [dmx_pkg::BYTE_W-1:0]  rd_data
);

    localparam int ADDR_W = $clog2(SLOT_COUNT);

    logic [dmx_pkg::BYTE_W-1:0] mem [SLOT_COUNT];
    logic [dmx_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        end
    end

    // a write landing on the same slot in the same cycle is passed through
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr[ADDR_W-1:0]];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/dmx_frame_ctrl.sv
// ----------------------------------------------------------------------------
// dmx_frame_ctrl
// Frame position, fill mark, timeout and light state, updated once per beat.
// ----------------------------------------------------------------------------
module dmx_frame_ctrl #(
    parameter int SLOT_COUNT = dmx_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [dmx_pkg::KIND_W-1:0]     kind,
    input  logic [dmx_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [dmx_pkg::SLOT_IDX_W-1:0] rd_addr,
    input  logic [dmx_pkg::BYTE_W-1:0]     rd_data,
    input  logic [dmx_pkg::TIMEOUT_W-1:0]  timeout_reload,
    output dmx_pkg::slot_wr_t              wr,
    output logic [dmx_pkg::BYTE_W-1:0]     read_data,
    output logic                           activity_led,
    output logic                           link_led
);

    localparam int POS_W  = $clog2(SLOT_COUNT + 3);
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W  = dmx_pkg::SLOT_IDX_W + 1;

    localparam logic [POS_W-1:0] P_IDLE  = POS_W'(dmx_pkg::POS_IDLE);
    localparam logic [POS_W-1:0] P_START = POS_W'(dmx_pkg::POS_START);
    localparam logic [POS_W-1:0] P_FIRST = POS_W'(dmx_pkg::POS_FIRST_SLOT);
    localparam logic [POS_W-1:0] P_END   = POS_W'(dmx_pkg::POS_FIRST_SLOT + SLOT_COUNT);

    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic [dmx_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic                          link_reg, link_next;
    logic                          act_reg, act_next;
    logic                          in_range;
    logic [dmx_pkg::BYTE_W-1:0]    slot_val;

    // slots at or above the fill mark were never written since reset
    assign in_range = CMP_W'(rd_addr) < CMP_W'(fill_reg);
    assign slot_val = in_range ? rd_data : '0;

    always_comb
    begin
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        timeout_next = timeout_reg;
        link_next    = link_reg;
        act_next     = act_reg;
        read_data    = '0;
        wr.en        = 1'b0;
        wr.addr      = dmx_pkg::SLOT_IDX_W'(pos_reg - P_FIRST);
        wr.data      = rx_byte;
        unique case (kind)
            dmx_pkg::KIND_DATA:
            begin
                if (pos_reg == P_START)
                begin
                    pos_next = (rx_byte == '0) ? P_FIRST : P_IDLE;
                end
                else if ((pos_reg != P_IDLE) && (pos_reg < P_END))
                begin
                    wr.en    = 1'b1;
                    pos_next = pos_reg + POS_W'(1);
                    if (FILL_W'(pos_reg - P_START) > fill_reg)
                    begin
                        fill_next = FILL_W'(pos_reg - P_START);
                    end
                end
            end
            dmx_pkg::KIND_BREAK:
            begin
                pos_next     = P_START;
                link_next    = 1'b1;
                timeout_next = timeout_reload;
                act_next     = slot_val != '0;
            end
            dmx_pkg::KIND_TICK:
            begin
                if (timeout_reg != '0)
                begin
                    timeout_next = timeout_reg - dmx_pkg::TIMEOUT_W'(1);
                end
                else
                begin
                    link_next = ~link_reg;
                end
            end
            dmx_pkg::KIND_READ:
            begin
                read_data = slot_val;
            end
            default:
            begin
                read_data = '0;
            end
        endcase
        if (!advance)
        begin
            wr.en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= P_IDLE;
            fill_reg    <= '0;
            timeout_reg <= dmx_pkg::TIMEOUT_AT_RESET;
            link_reg    <= 1'b1;
            act_reg     <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            timeout_reg <= timeout_next;
            link_reg    <= link_next;
            act_reg     <= act_next;
        end
    end

    assign activity_led = act_next;
    assign link_led     = link_next;

endmodule

>>> rtl/core/dmx_checker.sv
// ----------------------------------------------------------------------------
// dmx_checker
// Port-level checks for the dmx512 frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module dmx_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [15:0]                    m_tdata,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // an empty result register never backs up the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // an accepted beat reaches the output once the result register is free
    a_beat_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
        else $error("accepted beat did not reach the output");

    // config channel never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind dmx512_frame_receiver dmx_checker u_dmx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
